### hw/rtl/assert_macros.svh
// assertion helpers for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define CHK_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: property failed");

// checked at every edge, reset included
`define CHK_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("%m: property failed");

`endif

### hw/rtl/fir_pkg.sv
`default_nettype none

package fir_pkg;

  localparam int MAX_TAPS = 64;
  localparam int DATA_W   = 16;
  localparam int ADDR_W   = $clog2(MAX_TAPS);
  localparam int TAPS_W   = ADDR_W + 1;
  localparam int CFG_W    = 7;
  localparam int IDX_W    = 6;
  localparam int PROD_W   = 2 * DATA_W;
  localparam int ACC_W    = PROD_W + ADDR_W;
  localparam int FRAC_W   = DATA_W - 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } fir_state_t;

  typedef struct packed {
    logic start;
    logic issue;
    logic wr_coef;
    logic wr_sample;
    logic load_out;
  } fir_cmd_t;

  typedef struct packed {
    logic last_tap;
    logic pipe_empty;
  } fir_sts_t;

endpackage

`default_nettype wire

### hw/rtl/fir_ram.sv
`default_nettype none

module fir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/fir_ctrl.sv
`default_nettype none

module fir_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              kind,
  input  wire logic              out_stall,
  input  wire fir_pkg::fir_sts_t sts,
  output logic                   in_stall,
  output logic                   out_valid,
  output fir_pkg::fir_cmd_t      cmd
);

  fir_pkg::fir_state_t state;
  fir_pkg::fir_state_t state_next;
  logic                out_free;
  logic                accept;

  assign out_free = !out_valid || !out_stall;
  assign accept   = in_valid && (state == fir_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      fir_pkg::ST_IDLE: begin
        if (accept && !kind) begin
          state_next = fir_pkg::ST_ISSUE;
        end
      end
      fir_pkg::ST_ISSUE: begin
        if (sts.last_tap) begin
          state_next = fir_pkg::ST_DRAIN;
        end
      end
      fir_pkg::ST_DRAIN: begin
        if (sts.pipe_empty && out_free) begin
          state_next = fir_pkg::ST_IDLE;
        end
      end
      default: state_next = fir_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      fir_pkg::ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.start     = accept && !kind;
        cmd.wr_sample = accept && !kind;
        cmd.wr_coef   = accept && kind;
      end
      fir_pkg::ST_ISSUE: begin
        cmd.issue = 1'b1;
      end
      fir_pkg::ST_DRAIN: begin
        cmd.load_out = sts.pipe_empty && out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fir_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/fir_dp.sv
`default_nettype none

module fir_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic        [fir_pkg::CFG_W-1:0]  cfg_data,
  input  wire logic signed [fir_pkg::DATA_W-1:0] sample_in,
  input  wire logic        [fir_pkg::IDX_W-1:0]  coef_index,
  input  wire logic signed [fir_pkg::DATA_W-1:0] coef_value,
  input  wire fir_pkg::fir_cmd_t                 cmd,
  output fir_pkg::fir_sts_t                      sts,
  output logic signed      [fir_pkg::DATA_W-1:0] sample_out
);

  logic        [fir_pkg::CFG_W-1:0]  tap_count;
  logic        [fir_pkg::TAPS_W-1:0] eff_taps;
  logic        [fir_pkg::ADDR_W-1:0] wp;
  logic        [fir_pkg::ADDR_W-1:0] k;
  logic        [fir_pkg::ADDR_W-1:0] h_raddr;
  logic        [fir_pkg::ADDR_W-1:0] h_waddr;
  logic        [fir_pkg::ADDR_W-1:0] c_waddr;
  logic                              coef_ok;
  logic        [fir_pkg::MAX_TAPS-1:0] hist_vld;
  logic        [fir_pkg::MAX_TAPS-1:0] coef_vld;
  logic                              h_vq;
  logic                              c_vq;
  logic        [fir_pkg::DATA_W-1:0] h_rdata;
  logic        [fir_pkg::DATA_W-1:0] c_rdata;
  logic signed [fir_pkg::DATA_W-1:0] h_op;
  logic signed [fir_pkg::DATA_W-1:0] c_op;
  logic                              rd_v;
  logic                              prod_v;
  logic signed [fir_pkg::PROD_W-1:0] prod;
  logic signed [fir_pkg::ACC_W-1:0]  acc;
  logic signed [fir_pkg::ACC_W-1:0]  shifted;
  logic        [fir_pkg::ACC_W-fir_pkg::FRAC_W-1:0] hi;
  logic signed [fir_pkg::DATA_W-1:0] sat_val;

  // zero means one tap, above the table size means all taps
  always_comb begin
    if (tap_count == '0) begin
      eff_taps = fir_pkg::TAPS_W'(1);
    end else if (int'(tap_count) > fir_pkg::MAX_TAPS) begin
      eff_taps = fir_pkg::TAPS_W'(fir_pkg::MAX_TAPS);
    end else begin
      eff_taps = fir_pkg::TAPS_W'(tap_count);
    end
  end

  assign sts.last_tap   = ({1'b0, k} == (eff_taps - fir_pkg::TAPS_W'(1)));
  assign sts.pipe_empty = !rd_v && !prod_v;

  // oldest tap in use first, newest last
  assign h_waddr = wp + fir_pkg::ADDR_W'(1);
  assign h_raddr = wp - fir_pkg::ADDR_W'(eff_taps) + fir_pkg::ADDR_W'(1) + k;
  assign c_waddr = fir_pkg::ADDR_W'(coef_index);
  assign coef_ok = int'(coef_index) < fir_pkg::MAX_TAPS;

  fir_ram #(
    .WIDTH (fir_pkg::DATA_W),
    .DEPTH (fir_pkg::MAX_TAPS)
  ) u_hist (
    .clk   (clk),
    .we    (cmd.wr_sample),
    .waddr (h_waddr),
    .wdata (sample_in),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  fir_ram #(
    .WIDTH (fir_pkg::DATA_W),
    .DEPTH (fir_pkg::MAX_TAPS)
  ) u_coef (
    .clk   (clk),
    .we    (cmd.wr_coef && coef_ok),
    .waddr (c_waddr),
    .wdata (coef_value),
    .raddr (k),
    .rdata (c_rdata)
  );

  // entries never written read as zero
  assign h_op = h_vq ? signed'(h_rdata) : '0;
  assign c_op = c_vq ? signed'(c_rdata) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= fir_pkg::CFG_W'(fir_pkg::MAX_TAPS);
      wp        <= '0;
      k         <= '0;
      hist_vld  <= '0;
      coef_vld  <= '0;
      rd_v      <= 1'b0;
      prod_v    <= 1'b0;
    end else begin
      if (cfg_write) begin
        tap_count <= cfg_data;
      end
      if (cmd.wr_sample) begin
        wp                <= h_waddr;
        hist_vld[h_waddr] <= 1'b1;
      end
      if (cmd.wr_coef && coef_ok) begin
        coef_vld[c_waddr] <= 1'b1;
      end
      if (cmd.start) begin
        k <= '0;
      end else if (cmd.issue) begin
        k <= k + fir_pkg::ADDR_W'(1);
      end
      rd_v   <= cmd.issue;
      prod_v <= rd_v;
    end
  end

  always_ff @(posedge clk) begin
    h_vq <= hist_vld[h_raddr];
    c_vq <= coef_vld[k];
    prod <= h_op * c_op;
    if (cmd.start) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + fir_pkg::ACC_W'(prod);
    end
    if (cmd.load_out) begin
      sample_out <= sat_val;
    end
  end

  // floor shift, then clamp to the output range
  assign shifted = acc >>> fir_pkg::FRAC_W;
  assign hi      = shifted[fir_pkg::ACC_W-1:fir_pkg::FRAC_W];

  always_comb begin
    if ((&hi) || !(|hi)) begin
      sat_val = shifted[fir_pkg::DATA_W-1:0];
    end else if (shifted[fir_pkg::ACC_W-1]) begin
      sat_val = {1'b1, {(fir_pkg::DATA_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(fir_pkg::DATA_W-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

### hw/rtl/fir_filter_direct_form.sv
// channel  direction  handshake              payload
// in       to block   in_valid / in_stall    kind, sample_in, coef_index, coef_value
// out      from block out_valid / out_stall  sample_out
// cfg      to block   cfg_write              cfg_data (tap_count)
//
// a coefficient request is taken without stalling the input and gives no result
// a sample request stalls the input until its result is loaded into the output register,
// so no new sample is taken while one is in work: one shared multiply-accumulate walks
// the taps (tap_count held to 1..64), one per cycle, behind the registered ram reads
// the result sits in an output register; the next request is taken while it waits,
// and that request's last cycle stretches until the register frees
// reset clears history and coefficients through valid bits, no clearing pass
`default_nettype none

module fir_filter_direct_form (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              kind,
  input  wire logic signed [fir_pkg::DATA_W-1:0] sample_in,
  input  wire logic        [fir_pkg::IDX_W-1:0]  coef_index,
  input  wire logic signed [fir_pkg::DATA_W-1:0] coef_value,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed      [fir_pkg::DATA_W-1:0] sample_out,
  input  wire logic                              cfg_write,
  input  wire logic        [fir_pkg::CFG_W-1:0]  cfg_data
);

  fir_pkg::fir_cmd_t cmd;
  fir_pkg::fir_sts_t sts;

  fir_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .kind      (kind),
    .out_stall (out_stall),
    .sts       (sts),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  fir_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .sample_in  (sample_in),
    .coef_index (coef_index),
    .coef_value (coef_value),
    .cmd        (cmd),
    .sts        (sts),
    .sample_out (sample_out)
  );

endmodule

`default_nettype wire

### hw/rtl/fir_chk.sv
`default_nettype none
`include "assert_macros.svh"

module fir_chk (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic                       kind,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [fir_pkg::DATA_W-1:0] sample_out
);

  `CHK_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(sample_out))
  `CHK_ASSERT(a_sample_busy, clk, rst, in_valid && !in_stall && !kind |=> in_stall)
  `CHK_ASSERT(a_coef_fast, clk, rst, in_valid && !in_stall && kind |=> !in_stall)
  `CHK_ASSERT(a_out_from_work, clk, rst, $rose(out_valid) |-> $past(in_stall))
  `CHK_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !out_valid)

endmodule

bind fir_filter_direct_form fir_chk u_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .kind       (kind),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .sample_out (sample_out)
);

`default_nettype wire
